FILE: rtl/ahcd_pkg.sv
// Package: shared types, constants and hex decode for the ASCII hex command deframer.
`default_nettype none

package ahcd_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_CHK  = 2'd3
    } phase_t;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_CHK_OK   = 2'd1,
        KIND_BYPASS   = 2'd2,
        KIND_MISMATCH = 2'd3
    } kind_t;

    localparam int          TDATA_W        = 112;
    localparam int          CMD_BYTES      = 4;
    localparam int          MIN_LENGTH     = 8;
    localparam logic [7:0]  CHAR_X         = 8'h58;
    localparam logic [31:0] LEN_ALL_ONES   = 32'hffff_ffff;
    localparam int          APB_ADDR_W     = 2;
    localparam logic [APB_ADDR_W-1:0] REG_SOF_CHAR = 2'd0;
    localparam logic [7:0]  SOF_CHAR_RST   = 8'h23;

    // Decoded hex digit: bit 4 set means "not a hex digit"
    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.bad = 1'b0;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ascii_hex_command_deframer.sv
// Top level: byte-stream deframer for ASCII hex length/checksum command frames.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata[7:0] rx_byte
//  m_*     | out | m_tvalid / m_tready    | m_tuser result_kind, m_tdata packed
//  apb     | in  | psel+penable, pready=1 | sof_char at address 0
//
// One item per cycle sustained while results are taken: an input register feeds a single pass of
// hex decode, 32-bit sum and body-end compare, landing in the result register.
// m_tvalid comes from the result register, loaded as the item leaves the input register.
// The result register frees the input side: a new item is taken while the previous
// result waits, if the input register is empty or that result is being taken or absent.
// rst_n (async, active low) clears the parser and valid bits; sof_char returns to 8'h23.
`default_nettype none

module ascii_hex_command_deframer
    import ahcd_pkg::*;
#(
    parameter int LENGTH_DIGITS   = 4,
    parameter int MAX_BODY_BYTES  = 256,
    parameter int CHECKSUM_DIGITS = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,   // [7:0] data_byte, [15:8] data_index,
                                                  // [47:16] command_code,
                                                  // [63:48] frame_length,
                                                  // [95:64] checksum_sum,
                                                  // [111:96] checksum_received
    output logic [1:0]                 m_tuser,   // [1:0] result_kind
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int LEN_W = 4 * LENGTH_DIGITS;
    localparam int CHK_W = 4 * CHECKSUM_DIGITS;
    localparam int POS_W = $clog2(MAX_BODY_BYTES + 1);

    // configuration register
    logic [7:0] sof_char_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       proc_go;

    // parser state
    phase_t             phase_reg,     phase_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [LEN_W-1:0]   len_reg,       len_next;
    logic               len_stop_reg,  len_stop_next;
    logic [31:0]        cmd_reg,       cmd_next;
    logic [31:0]        sum_reg,       sum_next;
    logic [CHK_W-1:0]   chk_reg,       chk_next;
    logic               chk_stop_reg,  chk_stop_next;
    logic               all_x_reg,     all_x_next;

    // result of the current pass
    logic               res_valid;
    kind_t              res_kind;
    logic [7:0]         res_byte;
    logic [7:0]         res_index;
    logic [15:0]        res_rcv;

    // result register
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_index_reg;
    logic [31:0]        out_cmd_reg;
    logic [15:0]        out_len_reg;
    logic [31:0]        out_sum_reg;
    logic [15:0]        out_rcv_reg;

    hex_t               hx;
    logic [POS_W-1:0]   pos_inc;
    logic               body_end;

    // APB: zero wait states, one register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SOF_CHAR) ? {24'd0, sof_char_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sof_char_reg <= SOF_CHAR_RST;
        end else if (psel && penable && pwrite && pready && paddr == REG_SOF_CHAR) begin
            sof_char_reg <= pwdata[7:0];
        end
    end

    // input register handshake
    assign proc_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_go) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // shared decode terms
    assign hx       = hex_decode(in_byte_reg);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign body_end = (32'(pos_inc) == (32'(len_reg) - 32'(CMD_BYTES)))
                   || (pos_inc >= POS_W'(MAX_BODY_BYTES));

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        len_stop_next = len_stop_reg;
        cmd_next      = cmd_reg;
        sum_next      = sum_reg;
        chk_next      = chk_reg;
        chk_stop_next = chk_stop_reg;
        all_x_next    = all_x_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == sof_char_reg) begin
                    phase_next    = PH_LEN;
                    pos_next      = '0;
                    len_next      = '0;
                    len_stop_next = 1'b0;
                    cmd_next      = '0;
                    sum_next      = '0;
                    chk_next      = '0;
                    chk_stop_next = 1'b0;
                    all_x_next    = 1'b1;
                end
            end
            PH_LEN:
            begin
                sum_next = sum_reg + 32'(in_byte_reg);
                if (hx.bad) begin
                    len_stop_next = 1'b1;
                end else if (!len_stop_reg) begin
                    len_next = (len_reg << 4) | LEN_W'(hx.val);
                end
                pos_next = pos_inc;
                if (pos_inc >= POS_W'(LENGTH_DIGITS)) begin
                    pos_next = '0;
                    if (len_next < LEN_W'(MIN_LENGTH) || 32'(len_next) == LEN_ALL_ONES) begin
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                sum_next = sum_reg + 32'(in_byte_reg);
                if (pos_reg < POS_W'(CMD_BYTES)) begin
                    cmd_next = {cmd_reg[23:0], in_byte_reg};
                end
                pos_next = pos_inc;
                if (body_end) begin
                    phase_next = PH_CHK;
                    pos_next   = '0;
                end
            end
            PH_CHK:
            begin
                if (in_byte_reg != CHAR_X) begin
                    all_x_next = 1'b0;
                end
                if (hx.bad) begin
                    chk_stop_next = 1'b1;
                end else if (!chk_stop_reg) begin
                    chk_next = (chk_reg << 4) | CHK_W'(hx.val);
                end
                pos_next = pos_inc;
                if (pos_inc >= POS_W'(CHECKSUM_DIGITS)) begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // result of this pass
    always_comb
    begin
        res_valid = 1'b0;
        res_kind  = KIND_DATA;
        res_byte  = 8'd0;
        res_index = 8'd0;
        res_rcv   = 16'd0;
        case (phase_reg)
            PH_BODY:
            begin
                if (pos_reg >= POS_W'(CMD_BYTES)) begin
                    res_valid = 1'b1;
                    res_byte  = in_byte_reg;
                    res_index = 8'(pos_reg - POS_W'(CMD_BYTES));
                end
            end
            PH_CHK:
            begin
                if (pos_inc >= POS_W'(CHECKSUM_DIGITS)) begin
                    res_valid = 1'b1;
                    res_rcv   = 16'(chk_next);
                    if (all_x_next) begin
                        res_kind = KIND_BYPASS;
                    end else if (sum_reg == 32'(chk_next)) begin
                        res_kind = KIND_CHK_OK;
                    end else begin
                        res_kind = KIND_MISMATCH;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= PH_HUNT;
            pos_reg      <= '0;
            len_reg      <= '0;
            len_stop_reg <= 1'b0;
            cmd_reg      <= '0;
            sum_reg      <= '0;
            chk_reg      <= '0;
            chk_stop_reg <= 1'b0;
            all_x_reg    <= 1'b1;
        end else if (proc_go) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            len_stop_reg <= len_stop_next;
            cmd_reg      <= cmd_next;
            sum_reg      <= sum_next;
            chk_reg      <= chk_next;
            chk_stop_reg <= chk_stop_next;
            all_x_reg    <= all_x_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && res_valid) begin
            out_kind_reg  <= res_kind;
            out_byte_reg  <= res_byte;
            out_index_reg <= res_index;
            out_cmd_reg   <= cmd_next;
            out_len_reg   <= 16'(len_next);
            out_sum_reg   <= sum_next;
            out_rcv_reg   <= res_rcv;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_rcv_reg, out_sum_reg, out_len_reg, out_cmd_reg,
                       out_index_reg, out_byte_reg};

    // field counters stay inside their field
    a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEN |-> pos_reg < POS_W'(LENGTH_DIGITS))
        else $error("length digit position out of range");

    a_chk_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHK |-> pos_reg < POS_W'(CHECKSUM_DIGITS))
        else $error("checksum digit position out of range");

    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> (len_reg >= LEN_W'(MIN_LENGTH)
                                  && pos_reg < POS_W'(MAX_BODY_BYTES)))
        else $error("body entered with short length or past the cap");

    // results only come from body data or the checksum close
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PH_BODY || phase_reg == PH_CHK))
        else $error("result raised outside body or checksum phase");

    // a waiting result is not overwritten while stalled
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !proc_go)
        else $error("parser advanced over a stalled result");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the ASCII hex command deframer: framed byte streams against a local model.
`default_nettype none

module testbench;
    import ahcd_pkg::*;

    localparam int LENGTH_DIGITS   = 4;
    localparam int MAX_BODY_BYTES  = 256;
    localparam int CHECKSUM_DIGITS = 4;

    // Checksum field shapes the frame builder can produce
    typedef enum int {
        CK_GOOD,
        CK_BYPASS,
        CK_WRONG,
        CK_PART_X,
        CK_SHORT,
        CK_NOISE
    } chk_style_e;

    // One result item as it should leave the block
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [31:0] command_code;
        logic [15:0] frame_length;
        logic [31:0] checksum_sum;
        logic [15:0] checksum_received;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [1:0]            m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = 32'h0;
    logic [31:0]           prdata;
    logic                  pready;

    // Stimulus and expectation stores
    logic [7:0]    rx_queue[$];
    logic [7:0]    frame_buf[$];
    frame_result_t expected_results[$];
    int unsigned   frame_bytes_queued = 0;
    int unsigned   fail_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   sink_stall_pct = 0;

    // Deframer model state
    logic [7:0]  sof_char_reg = SOF_CHAR_RST;
    phase_t      parse_state = PH_HUNT;
    int unsigned field_pos = 0;
    logic [31:0] length_acc = 32'h0;
    bit          length_done = 1'b0;
    logic [31:0] cmd_word = 32'h0;
    logic [31:0] byte_sum = 32'h0;
    logic [31:0] chk_acc = 32'h0;
    bit          chk_done = 1'b0;
    bit          chk_all_x = 1'b1;

    ascii_hex_command_deframer #(
        .LENGTH_DIGITS  (LENGTH_DIGITS),
        .MAX_BODY_BYTES (MAX_BODY_BYTES),
        .CHECKSUM_DIGITS(CHECKSUM_DIGITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Hex digit value in [3:0]; bit 4 set for a non-hex byte
    function automatic logic [4:0] ascii_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h41 + 8'd10;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h61 + 8'd10;
        end
        else
        begin
            return 5'h10;
        end
        return {1'b0, d[3:0]};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'h30 + n;
        end
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(255));
        end
        while (ascii_nibble(c) != 5'h10);
        return c;
    endfunction

    // Append the low digits of a value, most significant first, random case
    function automatic void append_hex_digits(input logic [31:0] value,
                                              input int unsigned digits);
        for (int i = digits - 1; i >= 0; i--)
        begin
            frame_buf.push_back(hex_char(4'(value >> (4 * i)), 1'($urandom_range(1))));
        end
    endfunction

    // Advance the deframer model by one received byte; queue any result it causes
    task automatic deframe_byte(input logic [7:0] b);
        logic [4:0]    nib;
        frame_result_t r;
        r = '0;
        nib = ascii_nibble(b);
        case (parse_state)
            PH_HUNT:
            begin
                if (b == sof_char_reg)
                begin
                    field_pos   = 0;
                    length_acc  = 32'h0;
                    length_done = 1'b0;
                    cmd_word    = 32'h0;
                    byte_sum    = 32'h0;
                    chk_acc     = 32'h0;
                    chk_done    = 1'b0;
                    chk_all_x   = 1'b1;
                    parse_state = PH_LEN;
                end
            end
            PH_LEN:
            begin
                byte_sum += b;
                if (nib[4])
                begin
                    length_done = 1'b1;
                end
                else if (!length_done)
                begin
                    length_acc = {length_acc[27:0], nib[3:0]};
                end
                field_pos++;
                if (field_pos >= LENGTH_DIGITS)
                begin
                    field_pos = 0;
                    if (length_acc < MIN_LENGTH || length_acc == LEN_ALL_ONES)
                    begin
                        parse_state = PH_HUNT;
                    end
                    else
                    begin
                        parse_state = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                byte_sum += b;
                if (field_pos < CMD_BYTES)
                begin
                    cmd_word = {cmd_word[23:0], b};
                end
                else
                begin
                    r.kind         = KIND_DATA;
                    r.data_byte    = b;
                    r.data_index   = 8'(field_pos - CMD_BYTES);
                    r.command_code = cmd_word;
                    r.frame_length = length_acc[15:0];
                    r.checksum_sum = byte_sum;
                    expected_results.push_back(r);
                end
                field_pos++;
                if (field_pos == length_acc - 32'd4 || field_pos >= MAX_BODY_BYTES)
                begin
                    parse_state = PH_CHK;
                    field_pos   = 0;
                end
            end
            default:
            begin
                if (b != CHAR_X)
                begin
                    chk_all_x = 1'b0;
                end
                if (nib[4])
                begin
                    chk_done = 1'b1;
                end
                else if (!chk_done)
                begin
                    chk_acc = {chk_acc[27:0], nib[3:0]};
                end
                field_pos++;
                if (field_pos >= CHECKSUM_DIGITS)
                begin
                    if (chk_all_x)
                    begin
                        r.kind = KIND_BYPASS;
                    end
                    else if (byte_sum == chk_acc)
                    begin
                        r.kind = KIND_CHK_OK;
                    end
                    else
                    begin
                        r.kind = KIND_MISMATCH;
                    end
                    r.command_code      = cmd_word;
                    r.frame_length      = length_acc[15:0];
                    r.checksum_sum      = byte_sum;
                    r.checksum_received = chk_acc[15:0];
                    expected_results.push_back(r);
                    parse_state = PH_HUNT;
                    field_pos   = 0;
                end
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Build one frame with the current start character and queue its bytes
    task automatic queue_frame(input int unsigned len, input int unsigned len_digits,
                               input chk_style_e chk, input bit extreme_data,
                               input bit cut_short);
        logic [31:0] sum;
        logic [7:0]  c;
        int unsigned body_len;
        int unsigned keep;
        int unsigned nd;
        sum = 32'h0;
        frame_buf.delete();
        frame_buf.push_back(sof_char_reg);
        // length: leading digits, then non-hex filler
        append_hex_digits(len, len_digits);
        for (int i = len_digits; i < LENGTH_DIGITS; i++)
        begin
            frame_buf.push_back(non_hex_byte());
        end
        if (len >= MIN_LENGTH)
        begin
            body_len = (len - 4 > MAX_BODY_BYTES) ? MAX_BODY_BYTES : len - 4;
            for (int i = 0; i < body_len; i++)
            begin
                if (i < CMD_BYTES)
                begin
                    c = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : 8'(8'h41 + $urandom_range(25));
                end
                else if (extreme_data)
                begin
                    c = (i % 2 == 0) ? 8'h00 : 8'hFF;
                end
                else
                begin
                    case ($urandom_range(15))
                        0: c = 8'h00;
                        1: c = 8'hFF;
                        2: c = sof_char_reg;
                        default: c = 8'($urandom_range(255));
                    endcase
                end
                frame_buf.push_back(c);
            end
            foreach (frame_buf[i])
            begin
                if (i > 0)
                begin
                    sum += frame_buf[i];
                end
            end
            // checksum field
            case (chk)
                CK_GOOD:
                begin
                    append_hex_digits(sum, CHECKSUM_DIGITS);
                end
                CK_BYPASS:
                begin
                    repeat (CHECKSUM_DIGITS) frame_buf.push_back(CHAR_X);
                end
                CK_WRONG:
                begin
                    append_hex_digits(sum + $urandom_range(1, 65535), CHECKSUM_DIGITS);
                end
                CK_PART_X:
                begin
                    for (int i = 0; i < CHECKSUM_DIGITS; i++)
                    begin
                        if (i == CHECKSUM_DIGITS - 1 && $urandom_range(1))
                        begin
                            frame_buf.push_back(hex_char(4'($urandom_range(15)), 1'b0));
                        end
                        else if ($urandom_range(1))
                        begin
                            frame_buf.push_back(CHAR_X);
                        end
                        else
                        begin
                            frame_buf.push_back(hex_char(4'($urandom_range(15)),
                                                         1'($urandom_range(1))));
                        end
                    end
                    if (frame_buf[frame_buf.size() - 1] == CHAR_X)
                    begin
                        frame_buf[frame_buf.size() - 1] = 8'h30;
                    end
                end
                CK_SHORT:
                begin
                    // fewest digits that still carry the sum, then filler
                    nd = (sum < 16) ? 1 : (sum < 256) ? 2 : (sum < 4096) ? 3 : 4;
                    append_hex_digits(sum, nd);
                    for (int i = nd; i < CHECKSUM_DIGITS; i++)
                    begin
                        frame_buf.push_back(non_hex_byte());
                    end
                end
                default:
                begin
                    repeat (CHECKSUM_DIGITS) frame_buf.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        // broken frame: drop the tail
        if (cut_short)
        begin
            keep = $urandom_range(1, frame_buf.size() - 1);
            while (frame_buf.size() > keep)
            begin
                void'(frame_buf.pop_back());
            end
        end
        foreach (frame_buf[i])
        begin
            rx_queue.push_back(frame_buf[i]);
        end
        frame_bytes_queued += frame_buf.size();
    endtask

    // Hold until every queued item is taken and every result has come out
    task automatic wait_idle();
        while (rx_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_sof_char(input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SOF_CHAR;
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sof_char_reg = value;
    endtask

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Input driver: next item once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_queue.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: model each accepted item, check each accepted result
    always @(posedge clk)
    begin : monitor
        frame_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: kind %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, m_tuser);
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("data_index", want.data_index, m_tdata[15:8]);
                    check_field("command_code", want.command_code, m_tdata[47:16]);
                    check_field("frame_length", want.frame_length, m_tdata[63:48]);
                    check_field("checksum_sum", want.checksum_sum, m_tdata[95:64]);
                    check_field("checksum_received", want.checksum_received,
                                m_tdata[111:96]);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned len;
        int unsigned nd;
        int unsigned sel;
        int unsigned target;
        chk_style_e  chk;
        logic [7:0]  c;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: command-only frame, checksum bypassed
        queue_frame(8, LENGTH_DIGITS, CK_BYPASS, 1'b0, 1'b0);
        // length below the minimum returns to the hunt
        queue_frame(7, LENGTH_DIGITS, CK_GOOD, 1'b0, 1'b0);
        // one-digit length with filler, extreme data bytes, good checksum
        queue_frame(10, 1, CK_GOOD, 1'b1, 1'b0);
        wait_idle();

        // random phases: new start character and idle mix each
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_sof_char(8'h00);
                1: write_sof_char(8'hFF);
                2: write_sof_char(8'($urandom_range(255)));
                default: write_sof_char(CHAR_X);
            endcase
            send_idle_pct  = (p == 1) ? 76 : (p == 3) ? 36 : 0;
            sink_stall_pct = (p == 2) ? 76 : (p == 3) ? 36 : 0;
            // two halves, the sender pausing for a full drain in between
            for (int h = 0; h < 2; h++)
            begin
                target = frame_bytes_queued + 95;
                while (frame_bytes_queued < target)
                begin
                    sel = $urandom_range(99);
                    if (sel < 5)
                    begin
                        len = $urandom_range(7);
                    end
                    else if (sel < 74)
                    begin
                        len = $urandom_range(8, 24);
                    end
                    else if (sel < 91)
                    begin
                        len = $urandom_range(25, 64);
                    end
                    else if (sel < 96)
                    begin
                        len = $urandom_range(65, 258);
                    end
                    else
                    begin
                        case ($urandom_range(3))
                            0: len = 259;
                            1: len = 260;
                            2: len = 261;
                            default: len = $urandom_range(262, 65535);
                        endcase
                    end
                    nd = LENGTH_DIGITS;
                    if (len < 256 && $urandom_range(9) == 0)
                    begin
                        nd = (len < 16) ? $urandom_range(1, 3) : $urandom_range(2, 3);
                    end
                    sel = $urandom_range(99);
                    chk = (sel < 55) ? CK_GOOD : (sel < 67) ? CK_BYPASS :
                          (sel < 77) ? CK_WRONG : (sel < 85) ? CK_PART_X :
                          (sel < 93) ? CK_SHORT : CK_NOISE;
                    queue_frame(len, nd, chk, 1'b0, $urandom_range(99) < 6);
                    // line noise between frames, rarely the start character
                    repeat ($urandom_range(3))
                    begin
                        c = 8'($urandom_range(255));
                        if (c == sof_char_reg && $urandom_range(9) != 0)
                        begin
                            c = ~c;
                        end
                        rx_queue.push_back(c);
                    end
                end
                wait_idle();
            end
        end

        if (fail_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #1000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
